/* src/sss_pkg.sv */
// Shared types, constants and the segment decoder for the seven-segment scan shifter.
// No dependencies; imported by every module of the block.
package sss_pkg;

    localparam int NUM_DIGITS  = 4;
    localparam int DIGIT_W     = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] SCAN_PERIOD_RST = 16'd5;
    localparam logic [7:0]  SEG_BLANK       = 8'hFF;
    localparam logic [7:0]  SEL_FIRST       = 8'h80;
    localparam logic [3:0]  LAST_BIT        = 4'd15;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef struct packed {
        logic [7:0]         seg;
        logic [7:0]         sel;
        logic [DIGIT_W-1:0] digit;
    } t_frame;

    // active-low segments, decimal point in bit 0
    function automatic logic [7:0] seg_of(input logic [4:0] code);
        logic [7:0] s;
        unique case (code)
            5'd0:    s = 8'h03;
            5'd1:    s = 8'h9F;
            5'd2:    s = 8'h25;
            5'd3:    s = 8'h0D;
            5'd4:    s = 8'h99;
            5'd5:    s = 8'h49;
            5'd6:    s = 8'h41;
            5'd7:    s = 8'h1F;
            5'd8:    s = 8'h01;
            5'd9:    s = 8'h09;
            5'd10:   s = 8'hFF;
            5'd11:   s = 8'h02;
            5'd12:   s = 8'h9E;
            5'd13:   s = 8'h24;
            5'd14:   s = 8'h0C;
            5'd15:   s = 8'h98;
            5'd16:   s = 8'h48;
            5'd17:   s = 8'h40;
            5'd18:   s = 8'h1E;
            5'd19:   s = 8'h00;
            5'd20:   s = 8'h08;
            5'd21:   s = 8'hFE;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

    function automatic logic [1:0] shown_of(input logic [DIGIT_W-1:0] d);
        logic [DIGIT_W+1:0] t;
        t = {2'b00, d};
        return t[1:0];
    endfunction

endpackage

/* src/sss_front.sv */
// Front end: accepts requests, holds digit codes, scan period and prescaler,
// and queues one frame record per scan step. Depends on sss_pkg.
module sss_front import sss_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_opcode,
    input  logic [1:0]  i_digit_position,
    input  logic [4:0]  i_digit_code,
    input  logic        i_q_full,
    output logic        o_push,
    output t_frame      o_frame
);

    logic [15:0]        r_period;
    logic [15:0]        r_count;
    logic [DIGIT_W-1:0] r_digit;
    logic [4:0]         r_codes [NUM_DIGITS];

    logic accept;
    logic tick;
    logic fire;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign tick    = accept && (i_opcode == OP_TICK);
    assign fire    = tick && (r_count >= r_period);
    assign o_push  = fire;

    assign o_frame.seg   = seg_of(r_codes[r_digit]);
    assign o_frame.sel   = SEL_FIRST >> r_digit;
    assign o_frame.digit = r_digit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= SCAN_PERIOD_RST;
            r_count  <= '0;
            r_digit  <= '0;
            for (int i = 0; i < NUM_DIGITS; i++) begin
                r_codes[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_period <= i_cfg_data;
            end
            if (accept && (i_opcode == OP_WRITE)
                    && (32'(i_digit_position) < NUM_DIGITS)) begin
                r_codes[DIGIT_W'(i_digit_position)] <= i_digit_code;
            end
            if (fire) begin
                r_count <= '0;
                if (32'(r_digit) == NUM_DIGITS - 1) begin
                    r_digit <= '0;
                end else begin
                    r_digit <= r_digit + 1'b1;
                end
            end else if (tick) begin
                r_count <= r_count + 16'd1;
            end
        end
    end

endmodule

/* src/sss_queue.sv */
// Short frame queue between front end and shifter.
// Depends on sss_pkg (t_frame, QUEUE_DEPTH).
module sss_queue import sss_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_frame i_frame,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_empty,
    output t_frame o_frame
);

    t_frame            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (32'(r_cnt) == QUEUE_DEPTH);
    assign o_empty = (r_cnt == '0);
    assign o_frame = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (32'(r_wr) == QUEUE_DEPTH - 1) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (32'(r_rd) == QUEUE_DEPTH - 1) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* src/sss_back.sv */
// Shifter: takes one frame record and emits its 16 serial bits, one per request.
// Depends on sss_pkg.
module sss_back import sss_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_empty,
    input  t_frame     i_frame,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_serial_bit,
    output logic [3:0] o_bit_number,
    output logic [1:0] o_digit_shown,
    output logic       o_latch
);

    logic       r_busy;
    logic [3:0] r_bit;
    t_frame     r_frame;

    logic done;

    assign done  = r_busy && i_ready && (r_bit == LAST_BIT);
    assign o_pop = !i_q_empty && (!r_busy || done);

    assign o_valid       = r_busy;
    assign o_bit_number  = r_bit;
    assign o_digit_shown = shown_of(r_frame.digit);
    assign o_latch       = (r_bit == LAST_BIT);
    assign o_serial_bit  = r_bit[3] ? r_frame.sel[r_bit[2:0]] : r_frame.seg[r_bit[2:0]];

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_frame <= i_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_bit  <= '0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_bit  <= '0;
            end else if (done) begin
                r_busy <= 1'b0;
            end else if (r_busy && i_ready) begin
                r_bit <= r_bit + 4'd1;
            end
        end
    end

endmodule

/* src/seven_segment_scan_shifter.sv */
// Seven-segment scan shifter, top level. Uses sss_front, sss_queue, sss_back, sss_pkg.
// Throughput: one request per cycle while the two-entry frame queue has room;
// each frame is 16 output bits, one per cycle when the sink is ready.
// A frame's first bit is valid once its frame is queued and then popped by the shifter.
// Reset (synchronous, active low): scan period 5, prescaler, digit index, codes
// and queue cleared; no output is valid.
module seven_segment_scan_shifter import sss_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_opcode,
    input  logic [1:0]  i_digit_position,
    input  logic [4:0]  i_digit_code,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_serial_bit,
    output logic [3:0]  o_bit_number,
    output logic [1:0]  o_digit_shown,
    output logic        o_latch
);

    logic   q_full;
    logic   q_empty;
    logic   push;
    logic   pop;
    t_frame push_frame;
    t_frame head_frame;

    sss_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_opcode         (i_opcode),
        .i_digit_position (i_digit_position),
        .i_digit_code     (i_digit_code),
        .i_q_full         (q_full),
        .o_push           (push),
        .o_frame          (push_frame)
    );

    sss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_frame (push_frame),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_frame (head_frame)
    );

    sss_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_frame       (head_frame),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_serial_bit  (o_serial_bit),
        .o_bit_number  (o_bit_number),
        .o_digit_shown (o_digit_shown),
        .o_latch       (o_latch)
    );

`ifndef NO_ASSERTIONS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && q_full))
        else $error("frame pushed into full queue");

    a_bit_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_latch) |=>
            (o_valid && (o_bit_number == $past(o_bit_number) + 4'd1)))
        else $error("frame bit sequence broken");

    a_digit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_latch) |=> $stable(o_digit_shown))
        else $error("digit changed inside a frame");

    a_frame_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop) |=> (o_valid && (o_bit_number == 4'd0)))
        else $error("frame did not start at bit 0");
`endif

endmodule
